// File: rtl/cjd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cjd_pkg
// Types, constants and the month table shared by the date converter stages.
// ----------------------------------------------------------------------------
package cjd_pkg;

    localparam int YEAR_W = 18;
    localparam int TOD_W  = 17;   // seconds in a day, up to 86399
    localparam int DAYS_W = 28;
    localparam int JD_W   = 43;

    // ceil(2^24 / 100): exact quotient by 100 for any 17-bit year
    localparam logic [17:0] RECIP_100 = 18'd167773;
    localparam int          RECIP_SH  = 24;

    localparam logic signed [YEAR_W-1:0] YEAR_MAX   = 18'sd100000;
    localparam logic signed [YEAR_W-1:0] YEAR_MIN   = -18'sd100000;
    localparam logic signed [YEAR_W-1:0] GREG_YEAR  = 18'sd1582;
    localparam logic [3:0]               GREG_MONTH = 4'd10;
    localparam logic [4:0]               GREG_DAY   = 5'd15;

    localparam logic [37:0] HALF_DAY_S  = 38'd148694097600;
    localparam logic [17:0] SEC_PER_DAY = 18'd86400;

    // Stage 1 word: adjusted date plus time of day in seconds
    typedef struct packed {
        logic                     ok;
        logic                     greg;
        logic signed [YEAR_W-1:0] y;
        logic [3:0]               m;
        logic [4:0]               d;
        logic [TOD_W-1:0]         tod;
    } t_adj;

    // Stage 3 word: day number and time of day
    typedef struct packed {
        logic                     ok;
        logic signed [DAYS_W-1:0] days;
        logic [TOD_W-1:0]         tod;
    } t_day;

    // floor(30.6001 * (m + 1)) for adjusted months 3 to 14
    function automatic logic [8:0] month_days(input logic [3:0] m);
        logic [8:0] r;
        unique case (m)
            4'd3:    r = 9'd122;
            4'd4:    r = 9'd153;
            4'd5:    r = 9'd183;
            4'd6:    r = 9'd214;
            4'd7:    r = 9'd244;
            4'd8:    r = 9'd275;
            4'd9:    r = 9'd306;
            4'd10:   r = 9'd336;
            4'd11:   r = 9'd367;
            4'd12:   r = 9'd397;
            4'd13:   r = 9'd428;
            4'd14:   r = 9'd459;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/cjd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cjd_front
// Stage 1: bounds check, Jan/Feb shift to the year before, Gregorian test
// and time of day in seconds.
// ----------------------------------------------------------------------------
module cjd_front
    import cjd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_en,
    input  wire logic                     i_valid,
    input  wire logic signed [YEAR_W-1:0] i_year,
    input  wire logic [3:0]               i_month,
    input  wire logic [4:0]               i_day,
    input  wire logic [4:0]               i_hour,
    input  wire logic [5:0]               i_minute,
    input  wire logic [5:0]               i_second,
    output logic                          o_valid,
    output t_adj                          o_adj
);

    logic r_v;
    t_adj r_adj;
    t_adj n_adj;
    logic early;

    always_comb begin
        early        = (i_month <= 4'd2);
        n_adj.y      = early ? i_year - 18'sd1 : i_year;
        n_adj.m      = early ? i_month + 4'd12 : i_month;
        n_adj.d      = i_day;
        n_adj.ok     = (i_year <= YEAR_MAX) && (i_year >= YEAR_MIN) &&
                       (i_month >= 4'd1) && (i_month <= 4'd12) &&
                       (i_day >= 5'd1) && (i_hour <= 5'd23) &&
                       (i_minute <= 6'd59) && (i_second <= 6'd59);
        n_adj.greg   = (n_adj.y > GREG_YEAR) ||
                       ((n_adj.y == GREG_YEAR) &&
                        ((n_adj.m > GREG_MONTH) ||
                         ((n_adj.m == GREG_MONTH) && (i_day >= GREG_DAY))));
        n_adj.tod    = TOD_W'(i_hour) * 17'd3600 + TOD_W'(i_minute) * 17'd60 +
                       TOD_W'(i_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
        if (i_en) begin
            r_adj <= n_adj;
        end
    end

    assign o_valid = r_v;
    assign o_adj   = r_adj;

endmodule
`default_nettype wire

// File: rtl/cjd_days.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cjd_days
// Stages 2 and 3: century terms by reciprocal multiply, year and month day
// counts, then the day number.
// ----------------------------------------------------------------------------
module cjd_days
    import cjd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire t_adj i_adj,
    output logic      o_valid,
    output t_day      o_day
);

    // stage 2
    logic                 r_v2;
    logic                 r_ok2;
    logic                 r_greg2;
    logic [34:0]          r_p100;
    logic signed [28:0]   r_y1461;
    logic [8:0]           r_mdays;
    logic [4:0]           r_d2;
    logic [TOD_W-1:0]     r_tod2;

    // stage 3
    logic r_v3;
    t_day r_day;

    logic signed [28:0]       y_ext;
    logic [10:0]              q100;
    logic [8:0]               q400;
    logic signed [11:0]       b;
    logic signed [DAYS_W-1:0] n_days;

    // year is only positive and below 2^17 where the correction is used
    always_comb begin
        y_ext  = 29'(i_adj.y);
        q100   = r_p100[34:RECIP_SH];
        q400   = q100[10:2];
        b      = r_greg2 ? $signed(12'(q400) - 12'(q100)) : -12'sd2;
        n_days = DAYS_W'(r_y1461 >>> 2) + DAYS_W'(b) +
                 $signed({19'b0, r_mdays}) + $signed({23'b0, r_d2});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
        if (i_en) begin
            r_ok2     <= i_adj.ok;
            r_greg2   <= i_adj.greg;
            r_p100    <= 35'(i_adj.y[16:0]) * 35'(RECIP_100);
            r_y1461   <= y_ext * 29'sd1461;
            r_mdays   <= month_days(i_adj.m);
            r_d2      <= i_adj.d;
            r_tod2    <= i_adj.tod;
            r_day.ok   <= r_ok2;
            r_day.days <= n_days;
            r_day.tod  <= r_tod2;
        end
    end

    assign o_valid = r_v3;
    assign o_day   = r_day;

endmodule
`default_nettype wire

// File: rtl/cjd_scale.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cjd_scale
// Stages 4 and 5: days to seconds, add offset and time of day, output
// register. Out of bounds dates leave as zero.
// ----------------------------------------------------------------------------
module cjd_scale
    import cjd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire t_day              i_day,
    output logic                   o_valid,
    output logic                   o_valid_res,
    output logic signed [JD_W-1:0] o_jd_seconds
);

    logic                   r_v4;
    logic                   r_ok4;
    logic signed [44:0]     r_prod;
    logic [37:0]            r_tofs;

    logic                   r_v5;
    logic                   r_ok5;
    logic signed [JD_W-1:0] r_jd;

    logic signed [44:0] days_ext;
    logic [44:0]        sum;

    always_comb begin
        days_ext = 45'(i_day.days);
        sum      = r_prod + 45'(r_tofs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v4 <= i_valid;
            r_v5 <= r_v4;
        end
        if (i_en) begin
            r_ok4  <= i_day.ok;
            r_prod <= days_ext * $signed(45'(SEC_PER_DAY));
            r_tofs <= HALF_DAY_S + 38'(i_day.tod);
            r_ok5  <= r_ok4;
            r_jd   <= r_ok4 ? $signed(sum[JD_W-1:0]) : '0;
        end
    end

    assign o_valid      = r_v5;
    assign o_valid_res  = r_ok5;
    assign o_jd_seconds = r_jd;

endmodule
`default_nettype wire

// File: rtl/calendar_to_julian_date_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_to_julian_date_core
// Calendar date and time of day to Julian date in seconds, five stages.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          word
//  in       in   i_valid / o_stall  year, month, day, hour, minute, second
//  out      out  o_valid / i_stall  valid_res, jd_seconds
//
//  One word per cycle while the output word is not stalled; o_valid rises
//  once the word has passed through every stage below.
//  Stages: checks and Jan/Feb shift, century and year multiplies, day sum,
//  days by 86400 multiply, final add into the output register.
//  The whole pipe holds while the output word is stalled; o_stall follows.
//  Synchronous active-low reset clears the stage valid bits only.
// ----------------------------------------------------------------------------
module calendar_to_julian_date_core
    import cjd_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic signed [YEAR_W-1:0] i_year,
    input  wire logic [3:0]               i_month,
    input  wire logic [4:0]               i_day,
    input  wire logic [4:0]               i_hour,
    input  wire logic [5:0]               i_minute,
    input  wire logic [5:0]               i_second,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic                          o_valid_res,
    output logic signed [JD_W-1:0]        o_jd_seconds
);

    logic en;
    logic v1;
    logic v3;
    t_adj adj;
    t_day day;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    cjd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_year   (i_year),
        .i_month  (i_month),
        .i_day    (i_day),
        .i_hour   (i_hour),
        .i_minute (i_minute),
        .i_second (i_second),
        .o_valid  (v1),
        .o_adj    (adj)
    );

    cjd_days u_days (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v1),
        .i_adj   (adj),
        .o_valid (v3),
        .o_day   (day)
    );

    cjd_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (v3),
        .i_day        (day),
        .o_valid      (o_valid),
        .o_valid_res  (o_valid_res),
        .o_jd_seconds (o_jd_seconds)
    );

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_jd_seconds == '0))
        else $error("invalid date with nonzero result");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled output word lost");

endmodule
`default_nettype wire
